FILE: src/gts_pkg.sv
// Shared types and constants for the Gouraud triangle scanline fill core.
// No dependencies; used by gouraud_triangle_scanline_fill_core.
package gts_pkg;

  localparam int unsigned CFG_W    = 13;
  localparam int unsigned CH_BITS  = 8;
  localparam int unsigned RGB_BITS = 24;

  localparam logic [CFG_W-1:0] FRAME_LIMIT = 13'd4096;
  localparam logic [CFG_W-1:0] FRAME_W_RST = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_H_RST = 13'd480;

  // command codes carried in tuser
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SLOPE  = 9'b000000010,
    ST_SDIV   = 9'b000000100,
    ST_CROSS1 = 9'b000001000,
    ST_CROSS2 = 9'b000010000,
    ST_WALK   = 9'b000100000,
    ST_SPAN   = 9'b001000000,
    ST_PDIV   = 9'b010000000,
    ST_SKIP   = 9'b100000000
  } gts_state_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_TOP    = 2'd1,
    PH_BOTTOM = 2'd2
  } gts_phase_e;

endpackage

FILE: src/gts_div.sv
// Serial restoring divider, one quotient bit per cycle, signed dividend.
// Standalone; used by gouraud_triangle_scanline_fill_core.
module gts_div #(
  parameter int unsigned DW = 47,
  parameter int unsigned VW = 30
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] dividend_i,
  input  logic        [VW-1:0] divisor_i,  // nonzero
  output logic                 done_o,
  output logic signed [DW-1:0] quot_o
);

  localparam int unsigned CNTW = $clog2(DW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            neg_q, neg_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   mag_q, mag_d;
  logic [VW-1:0]   rem_q, rem_d;
  logic [VW-1:0]   dvs_q, dvs_d;
  logic [VW:0]     r2, rsub;
  logic            ge;

  assign r2   = {rem_q, mag_q[DW-1]};
  assign ge   = r2 >= {1'b0, dvs_q};
  assign rsub = r2 - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = dividend_i[DW-1];
      mag_d  = dividend_i[DW-1] ? DW'(-dividend_i) : DW'(dividend_i);
      rem_d  = '0;
      cnt_d  = CNTW'(DW);
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? rsub[VW-1:0] : r2[VW-1:0];
      mag_d = {mag_q[DW-2:0], ge};
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? $signed(-mag_q) : $signed(mag_q);

endmodule

FILE: src/gouraud_triangle_scanline_fill_core.sv
// Top level of the Gouraud triangle scanline fill core: setup, walk sequencer, I/O.
// Depends on gts_pkg and gts_div.
//
// A start item (tuser = 0) loads three vertices; the core sorts them by y and
// computes the edge slopes (x and r, g, b for each of a->b, a->c, b->c) in signed
// fixed point with FRAC_BITS fraction bits, then decides which side vertex b is on.
// Each step item (tuser = 1) returns one item: the next pixel inside the frame, or
// a done report. All divisions go through one serial divider that yields one
// quotient bit per cycle, so it is that unit that sets the timing. A start item
// runs one division for each slope with nonzero height (DW = COORD_BITS +
// 2 * FRAC_BITS + 3, 47 by default), then ST_CROSS1 and ST_CROSS2. A step item
// that lands on the next pixel of the current span passes ST_WALK once; every
// row change is another pass through ST_WALK, each new span of nonzero width
// adds three divisions for the color deltas, and a span that starts left of
// column 0 runs through ST_SKIP. The input is not ready while an item is in work or while a
// result waits on the output and is not taken in that same cycle. Frame width and
// height writes are taken any time; values above 4096 act as 4096.
module gouraud_triangle_scanline_fill_core #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16,
  localparam int unsigned VTX_W = 2 * COORD_BITS + gts_pkg::RGB_BITS,
  localparam int unsigned IN_W  = ((3 * VTX_W + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * COORD_BITS + gts_pkg::RGB_BITS + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input items
  input  logic                       s_tvalid_i,
  output logic                       s_tready_o,
  // vert0_x, vert0_y, vert0_rgb, vert1_x, vert1_y, vert1_rgb, vert2_x, vert2_y,
  // vert2_rgb
  input  logic [IN_W-1:0]            s_tdata_i,
  input  logic                       s_tuser_i,   // command
  // result items
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  output logic [OUT_W-1:0]           m_tdata_o,   // pixel_x, pixel_y, pixel_color
  output logic [1:0]                 m_tuser_o,   // pixel_valid, fill_done
  // configuration
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [gts_pkg::CFG_W-1:0]  cfg_data_i
);
  import gts_pkg::*;

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned FB  = FRAC_BITS;
  localparam int unsigned EW  = CB + FB + 2;       // edge position / color
  localparam int unsigned DW  = EW + 1 + FB;       // divider dividend
  localparam int unsigned CW  = FB + CH_BITS;      // span color, wraps mod 256
  localparam int unsigned RW  = CB + 2;            // row
  localparam int unsigned CLW = CB + 4;            // column
  localparam int unsigned CPW = CB + FB + 6;       // compare width

  // state
  gts_state_e             st_q, st_d;
  gts_phase_e             ph_q, ph_d;
  logic [CFG_W-1:0]       fw_q, fw_d, fh_q, fh_d;
  logic signed [CB-1:0]   vx_q [3], vx_d [3];
  logic signed [CB-1:0]   vy_q [3], vy_d [3];
  logic [RGB_BITS-1:0]    vc_q [3], vc_d [3];
  logic signed [EW-1:0]   sab_q [4], sab_d [4];
  logic signed [EW-1:0]   sac_q [4], sac_d [4];
  logic signed [EW-1:0]   sbc_q [4], sbc_d [4];
  logic signed [EW-1:0]   le_q [4], le_d [4];
  logic signed [EW-1:0]   re_q [4], re_d [4];
  logic [CW-1:0]          sd_q [3], sd_d [3];
  logic [CW-1:0]          sc_q [3], sc_d [3];
  logic signed [RW-1:0]   row_q, row_d;
  logic signed [CLW-1:0]  col_q, col_d;
  logic                   span_q, span_d;
  logic                   bright_q, bright_d;
  logic [1:0]             e_q, e_d, k_q, k_d;
  logic signed [2*CB+1:0] p1_q, p1_d;
  // output register
  logic                   mv_q, mv_d;
  logic [CB-1:0]          ox_q, ox_d, oy_q, oy_d;
  logic [RGB_BITS-1:0]    oc_q, oc_d;
  logic                   ov_q, ov_d, od_q, od_d;

  // divider
  logic                   div_start;
  logic signed [DW-1:0]   div_dvd;
  logic [EW-1:0]          div_dvs;
  logic                   div_done;
  logic signed [DW-1:0]   div_q;

  gts_div #(.DW(DW), .VW(EW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quot_o    (div_q)
  );

  // a result taken on this edge frees the output register for the next item
  logic s_acc;
  assign s_tready_o = (st_q == ST_IDLE) && (!mv_q || m_tready_i);
  assign s_acc      = s_tvalid_i && s_tready_o;

  // effective frame size
  logic [CFG_W-1:0] w_eff, h_eff;
  assign w_eff = (fw_q > FRAME_LIMIT) ? FRAME_LIMIT : fw_q;
  assign h_eff = (fh_q > FRAME_LIMIT) ? FRAME_LIMIT : fh_q;

  // next-row values, always computed from the current edges
  logic signed [EW-1:0] nle [4], nre [4], sl [4], sr [4];
  logic signed [RW-1:0] nrow;
  logic                 to_bottom, to_idle;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (ph_q == PH_TOP) begin
        sl[k] = bright_q ? sac_q[k] : sab_q[k];
        sr[k] = bright_q ? sab_q[k] : sac_q[k];
      end else begin
        sl[k] = bright_q ? sac_q[k] : sbc_q[k];
        sr[k] = bright_q ? sbc_q[k] : sac_q[k];
      end
      nle[k] = le_q[k] + sl[k];
      nre[k] = re_q[k] + sr[k];
    end
    nrow      = row_q + RW'(1);
    to_bottom = (ph_q == PH_TOP) && (nrow >= RW'(vy_q[1]));
    to_idle   = (ph_q == PH_BOTTOM) && (nrow > RW'(vy_q[2]));
  end

  // main sequencer
  logic signed [CB-1:0]   fvx, fvy, tvx, tvy;
  logic [RGB_BITS-1:0]    fvc, tvc;
  logic [CH_BITS-1:0]     fch, tch;
  logic signed [RW-1:0]   dy;
  logic signed [DW-1:0]   dnum;
  logic signed [EW:0]     spw;
  logic signed [EW:0]     cdiff;
  logic [CW-1:0]          negc;
  logic signed [CB-1:0]   ix [3], iy [3];
  logic [RGB_BITS-1:0]    ic [3];
  logic signed [CB-1:0]   tmpx, tmpy;
  logic [RGB_BITS-1:0]    tmpc;
  logic signed [2*CB+1:0] p2;
  logic                   nbr;
  logic                   fin;
  logic                   col_out;

  always_comb begin
    st_d = st_q; ph_d = ph_q; fw_d = fw_q; fh_d = fh_q;
    vx_d = vx_q; vy_d = vy_q; vc_d = vc_q;
    sab_d = sab_q; sac_d = sac_q; sbc_d = sbc_q;
    le_d = le_q; re_d = re_q; sd_d = sd_q; sc_d = sc_q;
    row_d = row_q; col_d = col_q; span_d = span_q; bright_d = bright_q;
    e_d = e_q; k_d = k_q; p1_d = p1_q;
    mv_d = mv_q; ox_d = ox_q; oy_d = oy_q; oc_d = oc_q; ov_d = ov_q; od_d = od_q;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;

    // configuration
    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_FRAME_WIDTH) fw_d = cfg_data_i;
      else fh_d = cfg_data_i;
    end
    if (mv_q && m_tready_i) mv_d = 1'b0;

    // edge select for slope setup
    case (e_q)
      2'd0: begin
        fvx = vx_q[0]; fvy = vy_q[0]; fvc = vc_q[0];
        tvx = vx_q[1]; tvy = vy_q[1]; tvc = vc_q[1];
      end
      2'd1: begin
        fvx = vx_q[0]; fvy = vy_q[0]; fvc = vc_q[0];
        tvx = vx_q[2]; tvy = vy_q[2]; tvc = vc_q[2];
      end
      default: begin
        fvx = vx_q[1]; fvy = vy_q[1]; fvc = vc_q[1];
        tvx = vx_q[2]; tvy = vy_q[2]; tvc = vc_q[2];
      end
    endcase
    case (k_q)
      2'd1:    begin fch = fvc[23:16]; tch = tvc[23:16]; end
      2'd2:    begin fch = fvc[15:8];  tch = tvc[15:8];  end
      default: begin fch = fvc[7:0];   tch = tvc[7:0];   end
    endcase
    dy = RW'(tvy) - RW'(fvy);
    if (k_q == 2'd0) dnum = DW'(tvx) - DW'(fvx);
    else dnum = $signed(DW'(tch)) - $signed(DW'(fch));

    // span setup values
    spw = (EW+1)'(re_q[0]) - (EW+1)'(le_q[0]);
    case (k_q)
      2'd0:    cdiff = (EW+1)'(re_q[1]) - (EW+1)'(le_q[1]);
      2'd1:    cdiff = (EW+1)'(re_q[2]) - (EW+1)'(le_q[2]);
      default: cdiff = (EW+1)'(re_q[3]) - (EW+1)'(le_q[3]);
    endcase
    negc = CW'(-col_q);

    // input unpack and stable sort by y
    for (int v = 0; v < 3; v++) begin
      ix[v] = s_tdata_i[v*VTX_W +: CB];
      iy[v] = s_tdata_i[v*VTX_W + CB +: CB];
      ic[v] = s_tdata_i[v*VTX_W + 2*CB +: RGB_BITS];
    end
    tmpx = '0; tmpy = '0; tmpc = '0;
    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin
        if (iy[1] > iy[2]) begin
          tmpx = ix[1]; tmpy = iy[1]; tmpc = ic[1];
          ix[1] = ix[2]; iy[1] = iy[2]; ic[1] = ic[2];
          ix[2] = tmpx;  iy[2] = tmpy;  ic[2] = tmpc;
        end
      end else begin
        if (iy[0] > iy[1]) begin
          tmpx = ix[0]; tmpy = iy[0]; tmpc = ic[0];
          ix[0] = ix[1]; iy[0] = iy[1]; ic[0] = ic[1];
          ix[1] = tmpx;  iy[1] = tmpy;  ic[1] = tmpc;
        end
      end
    end

    p2  = (2*CB+2)'((CB+1)'(vx_q[2]) - (CB+1)'(vx_q[0])) *
          (2*CB+2)'((CB+1)'(vy_q[1]) - (CB+1)'(vy_q[0]));
    nbr = p1_q > p2;

    fin     = (ph_q == PH_IDLE) || (CPW'(row_q) >= $signed(CPW'(h_eff)));
    col_out = (CPW'(col_q) >= $signed(CPW'(w_eff))) ||
              ((CPW'(col_q) <<< FB) >= CPW'(re_q[0]));

    case (st_q)
      ST_IDLE: begin
        if (s_acc) begin
          if (s_tuser_i == CMD_START) begin
            vx_d = ix; vy_d = iy; vc_d = ic;
            e_d  = 2'd0;
            k_d  = 2'd0;
            st_d = ST_SLOPE;
          end else begin
            st_d = ST_WALK;
          end
        end
      end

      ST_SLOPE, ST_SDIV: begin
        if (st_q == ST_SLOPE && dy != '0) begin
          div_start = 1'b1;
          div_dvd   = dnum <<< FB;
          div_dvs   = EW'(dy);
          st_d      = ST_SDIV;
        end else if (st_q == ST_SLOPE || div_done) begin
          case (e_q)
            2'd0:    sab_d[k_q] = (st_q == ST_SDIV) ? EW'(div_q) : '0;
            2'd1:    sac_d[k_q] = (st_q == ST_SDIV) ? EW'(div_q) : '0;
            default: sbc_d[k_q] = (st_q == ST_SDIV) ? EW'(div_q) : '0;
          endcase
          st_d = ST_SLOPE;
          if (k_q == 2'd3) begin
            k_d = 2'd0;
            if (e_q == 2'd2) st_d = ST_CROSS1;
            else e_d = e_q + 2'd1;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end

      ST_CROSS1: begin
        p1_d = (2*CB+2)'((CB+1)'(vx_q[1]) - (CB+1)'(vx_q[0])) *
               (2*CB+2)'((CB+1)'(vy_q[2]) - (CB+1)'(vy_q[0]));
        st_d = ST_CROSS2;
      end

      ST_CROSS2: begin
        bright_d = nbr;
        le_d[0] = EW'(vx_q[0]) <<< FB;
        for (int k = 1; k < 4; k++)
          le_d[k] = EW'(vc_q[0][RGB_BITS-1-8*(k-1) -: CH_BITS]) <<< FB;
        re_d   = le_d;
        row_d  = RW'(vy_q[0]);
        col_d  = '0;
        span_d = 1'b0;
        ph_d   = PH_TOP;
        // b on the top row: the bottom half starts at once from b
        if (vy_q[1] <= vy_q[0]) begin
          ph_d = PH_BOTTOM;
          if (nbr) begin
            re_d[0] = EW'(vx_q[1]) <<< FB;
            for (int k = 1; k < 4; k++)
              re_d[k] = EW'(vc_q[1][RGB_BITS-1-8*(k-1) -: CH_BITS]) <<< FB;
          end else begin
            le_d[0] = EW'(vx_q[1]) <<< FB;
            for (int k = 1; k < 4; k++)
              le_d[k] = EW'(vc_q[1][RGB_BITS-1-8*(k-1) -: CH_BITS]) <<< FB;
          end
        end
        st_d = ST_IDLE;
      end

      ST_WALK: begin
        if (fin) begin
          ph_d = PH_IDLE;
          mv_d = 1'b1;
          ox_d = '0; oy_d = '0; oc_d = '0; ov_d = 1'b0; od_d = 1'b1;
          st_d = ST_IDLE;
        end else if (!span_q && row_q >= 0) begin
          k_d  = 2'd0;
          st_d = ST_SPAN;
        end else if (span_q && col_q < 0 && re_q[0] > 0) begin
          k_d  = 2'd0;
          st_d = ST_SKIP;
        end else if (!span_q || col_q < 0 || col_out) begin
          // advance to the next row
          le_d   = nle;
          re_d   = nre;
          row_d  = nrow;
          span_d = 1'b0;
          if (to_bottom) begin
            ph_d = PH_BOTTOM;
            if (bright_q) begin
              re_d[0] = EW'(vx_q[1]) <<< FB;
              for (int k = 1; k < 4; k++)
                re_d[k] = EW'(vc_q[1][RGB_BITS-1-8*(k-1) -: CH_BITS]) <<< FB;
            end else begin
              le_d[0] = EW'(vx_q[1]) <<< FB;
              for (int k = 1; k < 4; k++)
                le_d[k] = EW'(vc_q[1][RGB_BITS-1-8*(k-1) -: CH_BITS]) <<< FB;
            end
          end else if (to_idle) begin
            ph_d = PH_IDLE;
          end
        end else begin
          mv_d = 1'b1;
          ox_d = col_q[CB-1:0];
          oy_d = row_q[CB-1:0];
          oc_d = {sc_q[0][CW-1 -: CH_BITS], sc_q[1][CW-1 -: CH_BITS],
                  sc_q[2][CW-1 -: CH_BITS]};
          ov_d = 1'b1;
          od_d = 1'b0;
          for (int k = 0; k < 3; k++) sc_d[k] = sc_q[k] + sd_q[k];
          col_d = col_q + CLW'(1);
          st_d  = ST_IDLE;
        end
      end

      ST_SPAN, ST_PDIV: begin
        if (st_q == ST_SPAN && spw > 0) begin
          div_start = 1'b1;
          div_dvd   = DW'(cdiff) <<< FB;
          div_dvs   = spw[EW-1:0];
          st_d      = ST_PDIV;
        end else if (st_q == ST_SPAN || div_done) begin
          sd_d[k_q] = (st_q == ST_PDIV) ? CW'(div_q) : '0;
          st_d = ST_SPAN;
          if (k_q == 2'd2) begin
            for (int k = 0; k < 3; k++) sc_d[k] = le_q[k+1][CW-1:0];
            col_d  = CLW'(le_q[0] >>> FB);
            span_d = 1'b1;
            st_d   = ST_WALK;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end

      ST_SKIP: begin
        // span starts left of column 0: jump the color to column 0
        sc_d[k_q] = sc_q[k_q] + negc * sd_q[k_q];
        if (k_q == 2'd2) begin
          col_d = '0;
          st_d  = ST_WALK;
        end else begin
          k_d = k_q + 2'd1;
        end
      end

      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      ph_q     <= PH_IDLE;
      fw_q     <= FRAME_W_RST;
      fh_q     <= FRAME_H_RST;
      span_q   <= 1'b0;
      bright_q <= 1'b0;
      e_q      <= '0;
      k_q      <= '0;
      mv_q     <= 1'b0;
    end else begin
      st_q     <= st_d;
      ph_q     <= ph_d;
      fw_q     <= fw_d;
      fh_q     <= fh_d;
      span_q   <= span_d;
      bright_q <= bright_d;
      e_q      <= e_d;
      k_q      <= k_d;
      mv_q     <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vx_q  <= vx_d;
    vy_q  <= vy_d;
    vc_q  <= vc_d;
    sab_q <= sab_d;
    sac_q <= sac_d;
    sbc_q <= sbc_d;
    le_q  <= le_d;
    re_q  <= re_d;
    sd_q  <= sd_d;
    sc_q  <= sc_d;
    row_q <= row_d;
    col_q <= col_d;
    p1_q  <= p1_d;
    ox_q  <= ox_d;
    oy_q  <= oy_d;
    oc_q  <= oc_d;
    ov_q  <= ov_d;
    od_q  <= od_d;
  end

  assign m_tvalid_o = mv_q;
  assign m_tdata_o  = OUT_W'({oc_q, oy_q, ox_q});
  assign m_tuser_o  = {od_q, ov_q};

endmodule

FILE: tb/sv/gts_fill_checker.sv
// Scoreboard for the Gouraud triangle scanline fill core: predicts every pixel and done item.
// Depends on gts_pkg; watches the input, output and configuration ports of the core.
`timescale 1ns / 100ps

module gts_fill_checker #(
  parameter int unsigned IN_W  = 144,
  parameter int unsigned OUT_W = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_tvalid_i,
  input  logic                      s_tready_i,
  input  logic [IN_W-1:0]           s_tdata_i,
  input  logic                      s_tuser_i,
  input  logic                      m_tvalid_i,
  input  logic                      m_tready_i,
  input  logic [OUT_W-1:0]          m_tdata_i,
  input  logic [1:0]                m_tuser_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [gts_pkg::CFG_W-1:0] cfg_data_i,
  output int                        errors_o,
  output int                        pending_o
);
  import gts_pkg::*;

  localparam int FB = 16;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [23:0] rgb;
    logic        vld;
    logic        done;
  } pixel_t;

  pixel_t expected_px[$];

  logic [CFG_W-1:0] fw, fh;
  longint vx[3], vy[3], vc[3][3];
  longint slope[3][4];
  longint le[4], re[4];
  longint pc[3], dl[3];
  longint row, col;
  bit span_on, b_right;
  gts_phase_e phase;

  assign pending_o = expected_px.size();

  function automatic longint fx_div(longint n, longint d);
    return d > 0 ? (n <<< FB) / d : 0;
  endfunction

  function automatic void set_slope(int e, int f, int t);
    longint dy;
    dy = vy[t] - vy[f];
    slope[e][0] = fx_div(vx[t] - vx[f], dy);
    for (int k = 1; k < 4; k++) slope[e][k] = fx_div(vc[t][k-1] - vc[f][k-1], dy);
  endfunction

  function automatic void load_edge(bit right, int v);
    longint t[4];
    t[0] = vx[v] <<< FB;
    for (int k = 1; k < 4; k++) t[k] = vc[v][k-1] <<< FB;
    for (int k = 0; k < 4; k++) if (right) re[k] = t[k]; else le[k] = t[k];
  endfunction

  function automatic void enter_bottom();
    phase = PH_BOTTOM;
    load_edge(b_right, 1);
  endfunction

  function automatic void next_row();
    int l, r;
    if (phase == PH_TOP) begin
      l = b_right ? 1 : 0;
      r = b_right ? 0 : 1;
    end else begin
      l = b_right ? 1 : 2;
      r = b_right ? 2 : 1;
    end
    for (int k = 0; k < 4; k++) begin
      le[k] += slope[l][k];
      re[k] += slope[r][k];
    end
    row++;
    span_on = 0;
    if (phase == PH_TOP && row >= vy[1]) enter_bottom();
    else if (phase == PH_BOTTOM && row > vy[2]) phase = PH_IDLE;
  endfunction

  function automatic void begin_span();
    longint wd;
    wd = re[0] - le[0];
    for (int k = 0; k < 3; k++) begin
      dl[k] = wd > 0 ? ((re[k+1] - le[k+1]) <<< FB) / wd : 0;
      pc[k] = le[k+1];
    end
    col = le[0] >>> FB;   // floor
    span_on = 1;
  endfunction

  function automatic void load_triangle(logic [IN_W-1:0] d);
    longint t;
    for (int i = 0; i < 3; i++) begin
      vx[i] = longint'($signed(d[48*i +: 12]));
      vy[i] = longint'($signed(d[48*i+12 +: 12]));
      for (int k = 0; k < 3; k++) vc[i][k] = longint'(d[48*i+24+8*(2-k) +: 8]);
    end
    // stable three-pass sort by y
    for (int p = 0; p < 3; p++) begin
      int i;
      i = (p == 1) ? 1 : 0;
      if (vy[i] > vy[i+1]) begin
        t = vx[i]; vx[i] = vx[i+1]; vx[i+1] = t;
        t = vy[i]; vy[i] = vy[i+1]; vy[i+1] = t;
        for (int k = 0; k < 3; k++) begin
          t = vc[i][k]; vc[i][k] = vc[i+1][k]; vc[i+1][k] = t;
        end
      end
    end
    set_slope(0, 0, 1);
    set_slope(1, 0, 2);
    set_slope(2, 1, 2);
    b_right = (vx[1] - vx[0]) * (vy[2] - vy[0]) > (vx[2] - vx[0]) * (vy[1] - vy[0]);
    load_edge(0, 0);
    load_edge(1, 0);
    row = vy[0];
    col = 0;
    span_on = 0;
    phase = PH_TOP;
    if (vy[1] <= row) enter_bottom();
  endfunction

  function automatic pixel_t next_pixel();
    longint w, h;
    pixel_t p;
    w = fw > FRAME_LIMIT ? 4096 : longint'(fw);
    h = fh > FRAME_LIMIT ? 4096 : longint'(fh);
    p = '0;
    forever begin
      if (phase == PH_IDLE || row >= h) begin
        phase = PH_IDLE;
        p.done = 1'b1;
        return p;
      end
      if (!span_on) begin
        if (row < 0) begin
          next_row();
          continue;
        end
        begin_span();
      end
      if (col < 0) begin
        if (re[0] <= 0) begin
          next_row();
          continue;
        end
        for (int k = 0; k < 3; k++) pc[k] += (-col) * dl[k];
        col = 0;
      end
      if (col >= w || (col <<< FB) >= re[0]) begin
        next_row();
        continue;
      end
      p.x   = col[11:0];
      p.y   = row[11:0];
      p.rgb = {pc[0][FB+7:FB], pc[1][FB+7:FB], pc[2][FB+7:FB]};
      p.vld = 1'b1;
      for (int k = 0; k < 3; k++) pc[k] += dl[k];
      col++;
      return p;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got, exp_px;
    if (!rst_ni) begin
      fw = FRAME_W_RST;
      fh = FRAME_H_RST;
      for (int i = 0; i < 3; i++) begin
        vx[i] = 0; vy[i] = 0; pc[i] = 0; dl[i] = 0;
        for (int k = 0; k < 3; k++) vc[i][k] = 0;
        for (int k = 0; k < 4; k++) slope[i][k] = 0;
      end
      for (int k = 0; k < 4; k++) begin
        le[k] = 0; re[k] = 0;
      end
      row = 0; col = 0; span_on = 0; b_right = 0;
      phase = PH_IDLE;
      errors_o = 0;
      expected_px.delete();
    end else begin
      // results first: an item accepted on this edge cannot have one yet
      if (m_tvalid_i && m_tready_i) begin
        got.x    = m_tdata_i[11:0];
        got.y    = m_tdata_i[23:12];
        got.rgb  = m_tdata_i[47:24];
        got.vld  = m_tuser_i[0];
        got.done = m_tuser_i[1];
        if (expected_px.size() == 0) begin
          $display("%0t: unexpected item x=%0d y=%0d rgb=%06h vld=%b done=%b", $time,
                   got.x, got.y, got.rgb, got.vld, got.done);
          errors_o++;
        end else begin
          exp_px = expected_px.pop_front();
          if (got.x !== exp_px.x) begin
            $display("%0t: pixel_x exp %0d got %0d", $time, exp_px.x, got.x);
            errors_o++;
          end
          if (got.y !== exp_px.y) begin
            $display("%0t: pixel_y exp %0d got %0d", $time, exp_px.y, got.y);
            errors_o++;
          end
          if (got.rgb !== exp_px.rgb) begin
            $display("%0t: pixel_color exp %06h got %06h", $time, exp_px.rgb, got.rgb);
            errors_o++;
          end
          if (got.vld !== exp_px.vld) begin
            $display("%0t: pixel_valid exp %b got %b", $time, exp_px.vld, got.vld);
            errors_o++;
          end
          if (got.done !== exp_px.done) begin
            $display("%0t: fill_done exp %b got %b", $time, exp_px.done, got.done);
            errors_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == CMD_START) load_triangle(s_tdata_i);
        else expected_px.push_back(next_pixel());
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FRAME_WIDTH) fw = cfg_data_i;
        else fh = cfg_data_i;
      end
    end
  end

endmodule

FILE: tb/sv/tb_gouraud_triangle_scanline_fill_core.sv
// Testbench top for the Gouraud triangle scanline fill core: stimulus, handshakes, verdict.
// Depends on gts_pkg, gouraud_triangle_scanline_fill_core and gts_fill_checker.
`timescale 1ns / 100ps

module tb_gouraud_triangle_scanline_fill_core;
  import gts_pkg::*;

  localparam int unsigned IN_W  = 144;
  localparam int unsigned OUT_W = 48;
  localparam int ITEM_TARGET = 550;
  localparam int STALL_LIMIT = 400000;  // worst step: ~480 off-frame rows of span setup
  localparam int CFG_SETTLE  = 800;     // a start item can still be running its slope divisions
  localparam int HOLD_AT     = 320;     // items sent before the long receiver hold-off
  localparam int HOLD_CYCLES = 500;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;     // vert0_x, vert0_y, vert0_rgb, vert1_x, ..., vert2_rgb
  logic             s_tuser;     // command
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;     // pixel_x, pixel_y, pixel_color
  logic [1:0]       m_tuser;     // pixel_valid, fill_done
  logic             cfg_we;
  logic             cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  int  errors, pending;
  int  items_sent;
  int  quiet_cycles;
  bit  gaps_on;        // random idling on both sides; off for stretches
  logic [CFG_W-1:0] cur_fh;

  always #5 clk_i = ~clk_i;

  gouraud_triangle_scanline_fill_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tuser_o  (m_tuser),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  gts_fill_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) pixel_scoreboard (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tuser_i  (m_tuser),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // Watchdog: cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random ready gaps, plus one long hold-off while the sender
  // keeps offering, so the core fills its output register and drops s_tready.
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    m_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && items_sent >= HOLD_AT) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = gaps_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  // Sends one item; tvalid stays high after acceptance unless the next item
  // idles first, so back-to-back items need only one assignment per edge.
  task automatic send_item(input logic cmd, input logic [IN_W-1:0] d);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= d;
    do @(posedge clk_i); while (!s_tready);
    items_sent++;
  endtask

  task automatic step_n(input int n);
    for (int i = 0; i < n; i++) send_item(CMD_STEP, IN_W'($urandom));
  endtask

  function automatic logic [47:0] vtx(input logic [11:0] x, input logic [11:0] y,
                                      input logic [23:0] rgb);
    return {rgb, y, x};
  endfunction

  // Mostly small triangles near the frame origin; wide ones reach every coordinate bit.
  function automatic logic [47:0] rand_vtx(input bit wide);
    logic [11:0] x, y;
    if (wide) begin
      x = 12'($urandom);
      y = 12'($urandom);
    end else begin
      x = 12'($urandom_range(0, 48)) - 12'd8;
      y = 12'($urandom_range(0, 40)) - 12'd6;
    end
    return vtx(x, y, 24'($urandom));
  endfunction

  // Config only with nothing in flight; the core may still be setting up a start.
  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (CFG_SETTLE) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_FRAME_WIDTH;
    cfg_data <= w;
    @(posedge clk_i);
    cfg_idx  <= CFG_FRAME_HEIGHT;
    cfg_data <= h;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cur_fh = h;
  endtask

  initial begin
    logic [CFG_W-1:0] fws[8], fhs[8];
    int ph;
    bit wide;
    fws = '{13'd640, 13'd0,   13'd4096, 13'd8191, 13'd1, 13'd37, 13'd13,   13'd640};
    fhs = '{13'd480, 13'd480, 13'd0,    13'd4096, 13'd1, 13'd23, 13'd8191, 13'd2};
    rst_ni   <= 1'b0;
    s_tvalid <= 1'b0;
    s_tuser  <= CMD_STEP;
    s_tdata  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CFG_FRAME_WIDTH;
    cfg_data <= '0;
    items_sent = 0;
    gaps_on = 1;
    cur_fh = FRAME_H_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset frame size.
    send_item(CMD_STEP, '0);                                   // step while idle
    send_item(CMD_START, {vtx(12'd2, 12'd1, 24'hFF0000),       // b right of long edge
                          vtx(12'd9, 12'd4, 24'h00FF00), vtx(12'd3, 12'd9, 24'h0000FF)});
    step_n(4);
    send_item(CMD_START, {vtx(12'd8, 12'd1, 24'h102030),       // b left, start mid-walk
                          vtx(12'd1, 12'd5, 24'hFFFFFF), vtx(12'd7, 12'd8, 24'h000000)});
    step_n(3);
    send_item(CMD_START, {vtx(12'd2, 12'd5, 24'h00FF80),       // all on one row, a right
                          vtx(12'd9, 12'd5, 24'h804000), vtx(12'd6, 12'd5, 24'hFF00FF)});
    step_n(3);
    send_item(CMD_START, {vtx(-12'd5, -12'd3, 24'hABCDEF),     // negative row and column
                          vtx(12'd4, 12'd2, 24'h123456), vtx(-12'd2, 12'd4, 24'h00FF00)});
    step_n(3);
    send_item(CMD_START, {vtx(12'h800, 12'h7FF, 24'hFFFFFF),   // coordinate extremes
                          vtx(12'h7FF, 12'h800, 24'h000000), vtx(12'h800, 12'h800, 24'h5A5AA5)});
    step_n(3);

    // Random part: start then a run of steps; short runs leave walks to be
    // restarted, long ones run past done.
    ph = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= 30 + 65 * ph && ph < 8) begin
        set_frame(fws[ph], fhs[ph]);
        gaps_on = (ph % 3) != 2;
        ph++;
      end
      wide = (cur_fh <= 13'd480) && ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 15) == 0) step_n($urandom_range(1, 3));  // noise
      send_item(CMD_START, {rand_vtx(wide), rand_vtx(wide), rand_vtx(wide)});
      step_n($urandom_range(1, 30));
    end
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
